FILE: src/fhf_pkg.sv
// Shared constants, types and address helper for the fire heat field engine.
package fhf_pkg;

	// Frame geometry
	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 32;
	localparam int CELL_COUNT   = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = $clog2(CELL_COUNT);
	localparam int COL_W        = $clog2(FRAME_WIDTH);
	localparam int ROW_W        = $clog2(FRAME_HEIGHT);
	localparam int STEP_W       = $clog2(FRAME_WIDTH + 2);

	// Port field widths
	localparam int FUNC_W = 2;
	localparam int COLF_W = 6;
	localparam int ROWF_W = 5;
	localparam int HEAT_W = 8;

	localparam int STAMP_SPAN = 8;

	// Cooling filter: new = sum * HEAT_GAIN / HEAT_DIV, divide done by reciprocal
	localparam int HEAT_GAIN = 30;
	localparam int HEAT_DIV  = 130;
	localparam int SUM_MAX   = 4 * ((1 << HEAT_W) - 1);
	localparam int SUM_W     = $clog2(SUM_MAX + 1);
	localparam int PROD_MAX  = SUM_MAX * HEAT_GAIN;
	localparam int PROD_W    = $clog2(PROD_MAX + 1);
	localparam int DIV_SHIFT = 24;
	localparam int DIV_RECIP = ((1 << DIV_SHIFT) + HEAT_DIV - 1) / HEAT_DIV;
	localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
	localparam int MUL_W     = PROD_W + RECIP_W;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Function codes on the command port
	localparam logic [FUNC_W-1:0] FUNC_STAMP   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

	typedef enum logic [1:0] {
		OP_STAMP   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	// Classified command as queued for the back end
	typedef struct packed {
		op_t                    op;
		logic [ADDR_W-1:0]      addr;
		logic [STAMP_SPAN-1:0]  bits;
		logic [HEAT_W-1:0]      value;
		logic                   out_of_frame;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Linear cell address of (row, column)
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(c);
	endfunction

endpackage

FILE: src/fhf_ram.sv
// Generic single-write, dual-read memory with registered read data.
module fhf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: src/fhf_front.sv
// Front end: accepts command transfers, range-checks and classifies them.
module fhf_front (
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic [fhf_pkg::FUNC_W-1:0] func,
	input  logic [fhf_pkg::COLF_W-1:0] col,
	input  logic [fhf_pkg::ROWF_W-1:0] row,
	input  logic [fhf_pkg::STAMP_SPAN-1:0] row_bits,
	input  logic [fhf_pkg::HEAT_W-1:0] heat_value,
	input  fhf_pkg::q_stat_t           q_stat,
	input  logic                       clearing,
	output logic                       push,
	output fhf_pkg::cmd_t              cmd
);
	import fhf_pkg::*;

	logic accept;
	logic row_ok;
	logic col_ok;

	// Hold off while the queue is full or the frame is being cleared
	assign cmd_stall = q_stat.full || clearing;
	assign accept    = cmd_valid && !cmd_stall;

	assign row_ok = int'(row) < FRAME_HEIGHT;
	assign col_ok = int'(col) < FRAME_WIDTH;

	// Decode; unused function code is taken and dropped
	always_comb begin
		cmd              = '0;
		push             = 1'b0;
		cmd.addr         = cell_addr(row, col);
		cmd.value        = heat_value;
		cmd.out_of_frame = !(row_ok && col_ok);
		// stamp cells past the right edge or below the frame are masked off
		for (int i = 0; i < STAMP_SPAN; i++) begin
			cmd.bits[i] = row_bits[i] && ((int'(col) + i) < FRAME_WIDTH) && row_ok;
		end
		case (func)
			FUNC_STAMP: begin
				cmd.op = OP_STAMP;
				push   = accept;
			end
			FUNC_ADVANCE: begin
				cmd.op = OP_ADVANCE;
				push   = accept;
			end
			FUNC_READ: begin
				cmd.op = OP_READ;
				push   = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

FILE: src/fhf_queue.sv
// Short command queue that decouples the front end from the back end.
module fhf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fhf_pkg::cmd_t    push_cmd,
	input  logic             pop,
	output fhf_pkg::cmd_t    head,
	output fhf_pkg::q_stat_t q_stat
);
	import fhf_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: src/fhf_back.sv
// Back end: frame memory, clear pass, stamp, read and advance sequencer.
module fhf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fhf_pkg::cmd_t              head,
	input  fhf_pkg::q_stat_t           q_stat,
	output logic                       pop,
	output logic                       clearing,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [fhf_pkg::HEAT_W-1:0] heat
);
	import fhf_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR   = 6'b000001,
		ST_IDLE    = 6'b000010,
		ST_STAMP   = 6'b000100,
		ST_ADV     = 6'b001000,
		ST_DRAIN   = 6'b010000,
		ST_RD_DATA = 6'b100000
	} state_t;

	state_t                 state_q;
	logic [ADDR_W-1:0]      clr_addr_q;
	logic [ADDR_W-1:0]      stp_addr_q;
	logic [STAMP_SPAN-1:0]  stp_bits_q;
	logic [HEAT_W-1:0]      stp_value_q;
	logic [ADDR_W-1:0]      rd_addr_q;
	logic                   rd_zero_q;
	logic [ROW_W-1:0]       y_q;
	logic [STEP_W-1:0]      k_q;
	logic [HEAT_W-1:0]      win_l_q;
	logic [HEAT_W-1:0]      win_c_q;
	logic                   adv_s1;
	logic                   calc_s1;
	logic [COL_W-1:0]       x_s1;
	logic [ROW_W-1:0]       y_s1;
	logic                   valid_s2;
	logic [PROD_W-1:0]      prod_s2;
	logic [ADDR_W-1:0]      addr_s2;
	logic                   valid_s3;
	logic [HEAT_W-1:0]      heat_s3;
	logic [ADDR_W-1:0]      addr_s3;
	logic                   rsp_valid_q;
	logic [HEAT_W-1:0]      heat_q;

	logic [ROW_W-1:0]  r1;
	logic [ROW_W-1:0]  r2;
	logic [COL_W-1:0]  col_a;
	logic [COL_W-1:0]  col_b;
	logic              k_last;
	logic              y_last;
	logic              out_free;
	logic [SUM_W-1:0]  sum;
	logic [MUL_W-1:0]  mul;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [HEAT_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic [HEAT_W-1:0] rdata_a;
	logic [HEAT_W-1:0] rdata_b;

	fhf_ram #(
		.WIDTH (HEAT_W),
		.DEPTH (CELL_COUNT)
	) u_frame (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign clearing  = state_q == ST_CLEAR;
	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign heat      = heat_q;

	// Advance sweep: rows below the one being rewritten, the lower wrapping to row 0; columns wrap
	assign k_last = k_q == STEP_W'(FRAME_WIDTH + 1);
	assign y_last = y_q == ROW_W'(FRAME_HEIGHT - 2);
	assign r1     = y_q + 1'b1;
	assign r2     = y_last ? '0 : y_q + ROW_W'(2);
	assign col_b  = COL_W'(k_q - STEP_W'(2));

	// Port A streams row r1 as: last column, 0, 1, ..., last column, 0
	always_comb begin
		if (k_q == '0) begin
			col_a = COL_W'(FRAME_WIDTH - 1);
		end else if (k_last) begin
			col_a = '0;
		end else begin
			col_a = COL_W'(k_q - 1'b1);
		end
	end

	// Read address selection
	always_comb begin
		case (state_q)
			ST_ADV:     raddr_a = cell_addr(r1, col_a);
			ST_RD_DATA: raddr_a = rd_addr_q;
			default:    raddr_a = head.addr;
		endcase
	end
	assign raddr_b = cell_addr(r2, col_b);

	// Write port: clear pass, stamp cells, or filter results
	always_comb begin
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = '0;
			end
			ST_STAMP: begin
				we    = stp_bits_q[0];
				waddr = stp_addr_q;
				wdata = stp_value_q;
			end
			default: begin
				we    = valid_s3;
				waddr = addr_s3;
				wdata = heat_s3;
			end
		endcase
	end

	// Filter arithmetic: window sum, then reciprocal multiply for the divide
	assign sum = SUM_W'(win_l_q) + SUM_W'(win_c_q) + SUM_W'(rdata_a) + SUM_W'(rdata_b);
	assign mul = MUL_W'(prod_s2) * MUL_W'(DIV_RECIP);

	// Sequencer and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			y_q         <= '0;
			k_q         <= '0;
			adv_s1      <= 1'b0;
			calc_s1     <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			adv_s1   <= state_q == ST_ADV;
			calc_s1  <= (state_q == ST_ADV) && (k_q >= STEP_W'(2));
			valid_s2 <= calc_s1;
			valid_s3 <= valid_s2;

			if ((state_q == ST_RD_DATA) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						case (head.op)
							OP_STAMP: begin
								if (head.bits != '0) begin
									state_q <= ST_STAMP;
								end
							end
							OP_ADVANCE: begin
								state_q <= ST_ADV;
								y_q     <= '0;
								k_q     <= '0;
							end
							OP_READ: begin
								state_q <= ST_RD_DATA;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_STAMP: begin
					if (stp_bits_q[STAMP_SPAN-1:1] == '0) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ADV: begin
					if (k_last) begin
						k_q <= '0;
						if (y_last) begin
							state_q <= ST_DRAIN;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// wait until the last results are written back
					if (!calc_s1 && !valid_s2 && !valid_s3) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_DATA: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			stp_addr_q  <= head.addr;
			stp_bits_q  <= head.bits;
			stp_value_q <= head.value;
			rd_addr_q   <= head.addr;
			rd_zero_q   <= head.out_of_frame;
		end else if (state_q == ST_STAMP) begin
			stp_bits_q <= stp_bits_q >> 1;
			stp_addr_q <= stp_addr_q + 1'b1;
		end

		x_s1 <= col_b;
		y_s1 <= y_q;

		// three-cell window over row r1
		if (adv_s1) begin
			win_l_q <= win_c_q;
			win_c_q <= rdata_a;
		end

		prod_s2 <= PROD_W'(sum * HEAT_GAIN);
		addr_s2 <= cell_addr(y_s1, x_s1);

		heat_s3 <= HEAT_W'(mul >> DIV_SHIFT);
		addr_s3 <= addr_s2;

		if ((state_q == ST_RD_DATA) && out_free) begin
			heat_q <= rd_zero_q ? '0 : rdata_a;
		end
	end

endmodule

FILE: src/fire_heat_field_engine_core.sv
// Fire heat field engine top level: front end, command queue, back end.
// Back end per command: a read waits in ST_RD_DATA while an earlier result is stalled, then
// registers its result and raises rsp_valid; a stamp steps through the cells from the first one
// up to the highest marked bit and writes the marked ones. An advance rewrites every row but the
// bottom one in a row sweep over the two frame read ports. Commands are executed one at a time.
// Reset: asynchronous, active low; afterwards a clearing pass over all FRAME_WIDTH*FRAME_HEIGHT
// cells zeroes the frame while cmd_stall is held high.
module fire_heat_field_engine_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  logic [fhf_pkg::FUNC_W-1:0] func,
	input  logic [fhf_pkg::COLF_W-1:0] col,
	input  logic [fhf_pkg::ROWF_W-1:0] row,
	input  logic [fhf_pkg::STAMP_SPAN-1:0] row_bits,
	input  logic [fhf_pkg::HEAT_W-1:0] heat_value,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [fhf_pkg::HEAT_W-1:0] heat
);
	import fhf_pkg::*;

	logic    push;
	logic    pop;
	logic    clearing;
	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;

	fhf_front u_front (
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.func       (func),
		.col        (col),
		.row        (row),
		.row_bits   (row_bits),
		.heat_value (heat_value),
		.q_stat     (q_stat),
		.clearing   (clearing),
		.push       (push),
		.cmd        (push_cmd)
	);

	fhf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	fhf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.heat      (heat)
	);

	// Queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_stat.full || pop))
		else $error("command queue overflow");

	// Back end only pops real entries
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("command queue underflow");

	// No command transfer while the frame is being cleared
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push)
		else $error("command taken during clearing pass");

	// A response is never raised directly on a pop
	a_rsp_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(pop))
		else $error("response raised directly on pop");

endmodule

FILE: sim/fire_heat_field_engine_core_tb.sv
// Self-checking testbench for the fire heat field engine: stamp, advance and read traffic.
`timescale 1ns / 1ps

module fire_heat_field_engine_core_tb;
	import fhf_pkg::*;

	// func 3 is not decoded by the block
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam int ADVANCE_CYCLES = (FRAME_HEIGHT - 1) * (FRAME_WIDTH + 2) + 4;
	// queue of two plus the command in flight, all of them advances
	localparam int TAIL_CYCLES    = (QUEUE_DEPTH + 1) * ADVANCE_CYCLES + 100;
	localparam int CYCLE_LIMIT    = 1_500_000;

	typedef struct {
		logic [HEAT_W-1:0] heat;
		logic [COLF_W-1:0] col;
		logic [ROWF_W-1:0] row;
	} heat_probe_t;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  cmd_valid  = 1'b0;
	logic                  cmd_stall;
	logic [FUNC_W-1:0]     func       = FUNC_STAMP;
	logic [COLF_W-1:0]     col        = '0;
	logic [ROWF_W-1:0]     row        = '0;
	logic [STAMP_SPAN-1:0] row_bits   = '0;
	logic [HEAT_W-1:0]     heat_value = '0;
	logic                  rsp_valid;
	logic                  rsp_stall  = 1'b0;
	logic [HEAT_W-1:0]     heat;

	// predicted frame contents and pending read results
	logic [HEAT_W-1:0] frame_mirror [FRAME_HEIGHT][FRAME_WIDTH];
	heat_probe_t       heat_expected [$];
	heat_probe_t       probe_head;

	int unsigned err_count     = 0;
	int unsigned cycle_count   = 0;
	int unsigned cmds_sent     = 0;
	int unsigned send_idle_pct = 0;
	int unsigned rsp_idle_pct  = 0;

	fire_heat_field_engine_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.func       (func),
		.col        (col),
		.row        (row),
		.row_bits   (row_bits),
		.heat_value (heat_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.heat       (heat)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Frame predictor
	// ---------------------------------------------------------------
	function automatic void clear_mirror();
		for (int y = 0; y < FRAME_HEIGHT; y++)
			for (int x = 0; x < FRAME_WIDTH; x++)
				frame_mirror[y][x] = '0;
	endfunction

	// marked cells past the right edge or bottom are dropped, no wrap
	function automatic void stamp_mirror(input int unsigned c, input int unsigned r,
			input logic [STAMP_SPAN-1:0] b, input logic [HEAT_W-1:0] v);
		if (r < FRAME_HEIGHT) begin
			for (int unsigned i = 0; i < STAMP_SPAN; i++) begin
				if (b[i] && (c + i < FRAME_WIDTH))
					frame_mirror[r][c + i] = v;
			end
		end
	endfunction

	// in-place top-down cooling sweep; bottom row untouched
	function automatic void advance_mirror();
		int unsigned r1, r2, xl, xr, sum, cooled;
		for (int unsigned y = 0; y + 1 < FRAME_HEIGHT; y++) begin
			r1 = (y + 1) % FRAME_HEIGHT;
			r2 = (y + 2) % FRAME_HEIGHT;
			for (int unsigned x = 0; x < FRAME_WIDTH; x++) begin
				xl = (x + FRAME_WIDTH - 1) % FRAME_WIDTH;
				xr = (x + 1) % FRAME_WIDTH;
				sum = frame_mirror[r1][xl] + frame_mirror[r1][x]
					+ frame_mirror[r1][xr] + frame_mirror[r2][x];
				cooled = (sum * HEAT_GAIN) / HEAT_DIV;
				if (cooled > 255)
					cooled = 255;
				frame_mirror[y][x] = HEAT_W'(cooled);
			end
		end
	endfunction

	function automatic logic [HEAT_W-1:0] heat_at(input int unsigned c, input int unsigned r);
		if (c < FRAME_WIDTH && r < FRAME_HEIGHT)
			return frame_mirror[r][c];
		return '0;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers; callers are positioned at a falling edge
	// ---------------------------------------------------------------
	task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [COLF_W-1:0] c,
			input logic [ROWF_W-1:0] r, input logic [STAMP_SPAN-1:0] b,
			input logic [HEAT_W-1:0] v);
		heat_probe_t probe;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid  <= 1'b1;
		func       <= f;
		col        <= c;
		row        <= r;
		row_bits   <= b;
		heat_value <= v;
		do
			@(posedge clk);
		while (cmd_stall);
		@(negedge clk);
		// transfer accepted: update the predicted frame in command order
		case (f)
			FUNC_STAMP:   stamp_mirror(c, r, b, v);
			FUNC_ADVANCE: advance_mirror();
			FUNC_READ: begin
				probe.heat = heat_at(c, r);
				probe.col  = c;
				probe.row  = r;
				heat_expected.push_back(probe);
			end
			default: ;
		endcase
		if (f != FUNC_UNUSED)
			cmds_sent++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0d ns: %s", $time, msg);
		err_count++;
	endtask

	// ---------------------------------------------------------------
	// Result checker and response-side stall
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (heat_expected.size() == 0) begin
				report_mismatch($sformatf("result heat=%0d with no read pending", heat));
			end else begin
				probe_head = heat_expected.pop_front();
				if (heat !== probe_head.heat)
					report_mismatch($sformatf("read row %0d col %0d: heat %0d, expected %0d",
						probe_head.row, probe_head.col, heat, probe_head.heat));
			end
		end
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// stamps at the right edge, empty masks, zero heat, no column wrap
	task automatic test_stamp_edges();
		send_cmd(FUNC_STAMP, 6'd60, 5'd31, 8'hFF, 8'hFF);
		send_cmd(FUNC_READ,  6'd63, 5'd31, 8'h00, 8'h00);
		send_cmd(FUNC_READ,  6'd0,  5'd31, 8'h00, 8'h00);
		send_cmd(FUNC_STAMP, 6'd0,  5'd0,  8'h01, 8'h00);
		send_cmd(FUNC_STAMP, 6'd0,  5'd0,  8'h00, 8'hFF);
		send_cmd(FUNC_READ,  6'd0,  5'd0,  8'h00, 8'h00);
		send_cmd(FUNC_STAMP, 6'd56, 5'd0,  8'h80, 8'hA5);
		send_cmd(FUNC_READ,  6'd63, 5'd0,  8'hFF, 8'hFF);
	endtask

	// undecoded function must neither write nor answer
	task automatic test_unused_func();
		send_cmd(FUNC_UNUSED, 6'd63, 5'd31, 8'hFF, 8'hFF);
		send_cmd(FUNC_UNUSED, 6'd0,  5'd0,  8'h00, 8'h00);
		send_cmd(FUNC_READ,   6'd63, 5'd31, 8'h00, 8'h00);
	endtask

	// peak cooled value, row height-2 seeing the fresh row 0, column wrap, bottom row kept
	task automatic test_advance_rules();
		send_cmd(FUNC_STAMP,   6'd8,  5'd30, 8'hFF, 8'd255);
		send_cmd(FUNC_STAMP,   6'd8,  5'd31, 8'hFF, 8'd255);
		send_cmd(FUNC_STAMP,   6'd20, 5'd1,  8'hFF, 8'd200);
		send_cmd(FUNC_STAMP,   6'd20, 5'd2,  8'hFF, 8'd200);
		send_cmd(FUNC_ADVANCE, 6'd63, 5'd31, 8'hFF, 8'hFF);
		send_cmd(FUNC_READ,    6'd10, 5'd29, 8'h00, 8'h00);
		send_cmd(FUNC_READ,    6'd22, 5'd30, 8'h00, 8'h00);
		send_cmd(FUNC_READ,    6'd22, 5'd0,  8'h00, 8'h00);
		send_cmd(FUNC_READ,    6'd63, 5'd31, 8'h00, 8'h00);
		send_cmd(FUNC_READ,    6'd63, 5'd30, 8'h00, 8'h00);
		send_cmd(FUNC_READ,    6'd0,  5'd30, 8'h00, 8'h00);
	endtask

	// one burst: stamp a few stacked rows, let it burn, probe the area
	task automatic send_fire_scene();
		int unsigned n_stamp, n_read, base_col, base_row, c, r;
		logic [STAMP_SPAN-1:0] b;
		logic [HEAT_W-1:0] v;
		n_stamp  = $urandom_range(1, 4);
		base_col = $urandom_range(0, FRAME_WIDTH - 1);
		base_row = $urandom_range(1) ? $urandom_range(FRAME_HEIGHT - 6, FRAME_HEIGHT - 1)
			: $urandom_range(0, FRAME_HEIGHT - 1);
		for (int unsigned k = 0; k < n_stamp; k++) begin
			c = ($urandom_range(3) == 0) ? $urandom_range(0, FRAME_WIDTH - 1) : base_col;
			r = (base_row + k) % FRAME_HEIGHT;
			b = ($urandom_range(2) == 0) ? 8'hFF : STAMP_SPAN'($urandom());
			v = ($urandom_range(3) == 0) ? 8'hFF : HEAT_W'($urandom());
			send_cmd(FUNC_STAMP, COLF_W'(c), ROWF_W'(r), b, v);
		end
		if ($urandom_range(99) < 55)
			send_cmd(FUNC_ADVANCE, COLF_W'($urandom()), ROWF_W'($urandom()),
				STAMP_SPAN'($urandom()), HEAT_W'($urandom()));
		if ($urandom_range(99) < 10)
			send_cmd(FUNC_ADVANCE, COLF_W'($urandom()), ROWF_W'($urandom()),
				STAMP_SPAN'($urandom()), HEAT_W'($urandom()));
		n_read = $urandom_range(2, 6);
		for (int unsigned k = 0; k < n_read; k++) begin
			if ($urandom_range(3) == 0) begin
				c = $urandom_range(0, FRAME_WIDTH - 1);
				r = $urandom_range(0, FRAME_HEIGHT - 1);
			end else begin
				c = (base_col + $urandom_range(0, 9) + FRAME_WIDTH - 1) % FRAME_WIDTH;
				r = (base_row + FRAME_HEIGHT - $urandom_range(0, 4)) % FRAME_HEIGHT;
			end
			send_cmd(FUNC_READ, COLF_W'(c), ROWF_W'(r),
				STAMP_SPAN'($urandom()), HEAT_W'($urandom()));
		end
		// noise: undecoded function
		if ($urandom_range(9) == 0)
			send_cmd(FUNC_UNUSED, COLF_W'($urandom()), ROWF_W'($urandom()),
				STAMP_SPAN'($urandom()), HEAT_W'($urandom()));
	endtask

	task automatic test_random_fire(input int unsigned send_pct, input int unsigned rsp_pct,
			input int unsigned n_items);
		int unsigned stop_at;
		send_idle_pct = send_pct;
		rsp_idle_pct  = rsp_pct;
		stop_at = cmds_sent + n_items;
		while (cmds_sent < stop_at)
			send_fire_scene();
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		int unsigned tail;
		clear_mirror();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 14;
		rsp_idle_pct  = 57;
		test_stamp_edges();
		test_unused_func();
		test_advance_rules();

		test_random_fire(14, 57, 90);
		test_random_fire(57, 14, 90);
		test_random_fire(0, 0, 90);

		// drain: wait for every read, then for any trailing advance
		cmd_valid <= 1'b0;
		rsp_idle_pct = 0;
		while (heat_expected.size() != 0)
			@(negedge clk);
		tail = TAIL_CYCLES;
		repeat (tail) @(negedge clk);
		if (heat_expected.size() != 0)
			report_mismatch($sformatf("%0d read results never arrived", heat_expected.size()));

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
